// ----- rtl/dkg_pkg.sv -----
// Shared types, constants and AES helpers for the DCF key generator.
// No dependencies; imported by every module of the block.
package dkg_pkg;

    localparam int unsigned InWidth  = 384;
    localparam int unsigned OutWidth = 520;
    localparam logic [6:0]  MaxLevels = 7'd64;
    localparam logic [3:0]  LastRound = 4'd10;
    localparam logic [2:0]  LastEnc   = 3'd7;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_ROUND = 8'b0000_0100,
        S_VAL   = 8'b0000_1000,
        S_V2    = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } dkg_state_t;

    typedef struct packed {
        logic [7:0] rcon;
        logic       final_round;
    } dkg_round_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            default: r = 8'h36;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] cond_neg(input logic neg, input logic [63:0] x);
        return neg ? (64'd0 - x) : x;
    endfunction

endpackage

// ----- rtl/dkg_aes_round.sv -----
// One AES-128 round with on-the-fly key schedule step.
// Depends on dkg_pkg (S-box, xtime, round control struct).
module dkg_aes_round import dkg_pkg::*; (
    input  logic [127:0]   state_in,
    input  logic [127:0]   key_in,
    input  dkg_round_ctl_t ctl,
    output logic [127:0]   state_out,
    output logic [127:0]   key_out
);

    logic [7:0] sb   [16];
    logic [7:0] mc   [16];
    logic [7:0] t    [4];
    logic [31:0] w   [4];
    logic [7:0] a0, a1, a2, a3, all;

    always_comb begin
        // next round key
        t[0] = SBOX[key_in[111:104]] ^ ctl.rcon;
        t[1] = SBOX[key_in[119:112]];
        t[2] = SBOX[key_in[127:120]];
        t[3] = SBOX[key_in[103:96]];
        w[0] = key_in[31:0] ^ {t[3], t[2], t[1], t[0]};
        w[1] = key_in[63:32] ^ w[0];
        w[2] = key_in[95:64] ^ w[1];
        w[3] = key_in[127:96] ^ w[2];
        key_out = {w[3], w[2], w[1], w[0]};

        // sub bytes and shift rows
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                sb[c*4+j] = SBOX[state_in[(((c+j)%4)*4+j)*8 +: 8]];
            end
        end

        // mix columns
        for (int c = 0; c < 4; c++) begin
            a0 = sb[c*4];
            a1 = sb[c*4+1];
            a2 = sb[c*4+2];
            a3 = sb[c*4+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            mc[c*4]   = ctl.final_round ? a0 : (a0 ^ all ^ xtime(a0 ^ a1));
            mc[c*4+1] = ctl.final_round ? a1 : (a1 ^ all ^ xtime(a1 ^ a2));
            mc[c*4+2] = ctl.final_round ? a2 : (a2 ^ all ^ xtime(a2 ^ a3));
            mc[c*4+3] = ctl.final_round ? a3 : (a3 ^ all ^ xtime(a3 ^ a0));
        end

        for (int i = 0; i < 16; i++) begin
            state_out[i*8 +: 8] = mc[i] ^ key_out[i*8 +: 8];
        end
    end

endmodule

// ----- rtl/dcf_key_generation.sv -----
// Top level of the DCF key generator: sequencer, seed and value datapath.
// Depends on dkg_pkg and dkg_aes_round.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write bin_bits (levels per request, 0 acts
//   as 1, above 64 acts as 64). Write it only while the block is idle.
//   s_tvalid/s_tready/s_tdata take one request. s_tready is high only while
//   no request is in progress.
//   m_tvalid/m_tready/m_tdata/m_tlast return one transaction per level,
//   level 0 first; m_tlast marks the final one, which also carries the
//   root seeds and the output correction.
// Sequence:
//   Each level runs eight AES-128 encryptions (four per party seed) on one
//   shared round unit, each a load step (S_INIT) and ten rounds (S_ROUND).
//   The S_VAL, S_V2 and S_UPD states then form the value and seed
//   corrections, and the result waits in the output register until taken.
//   The last level also passes S_FIN, which adds the root seeds and the
//   output correction.
// Reset: aresetn low clears the sequencer to idle and bin_bits to 64.
// Stall: while m_tready is low the result is held and the sequencer waits.
module dcf_key_generation import dkg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // alpha[63:0], payload[127:64], seed0_lo[191:128], seed0_hi[255:192],
    // seed1_lo[319:256], seed1_hi[383:320]
    input  logic [InWidth-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // level[5:0], cw_lo[69:6], cw_hi[133:70], value_cw[197:134],
    // root0_lo[261:198], root0_hi[325:262], root1_lo[389:326],
    // root1_hi[453:390], output_cw[517:454], zero fill [519:518]
    output logic [OutWidth-1:0] m_tdata,
    output logic                m_tlast
);

    dkg_state_t   state_reg, state_next;
    logic [6:0]   bin_bits_reg;
    logic [6:0]   nb_reg;
    logic [5:0]   lvl_reg;
    logic [2:0]   enc_reg;
    logic [3:0]   rnd_reg;
    logic [63:0]  alpha_reg;
    logic [63:0]  payload_reg;
    logic [127:0] p0_reg, p1_reg;
    logic [127:0] root0_reg, root1_reg;
    logic [63:0]  acc_reg;
    logic [63:0]  tmp_reg;
    logic [63:0]  v0_reg;
    logic [127:0] aes_st_reg, aes_key_reg;
    logic [127:0] ct_reg [8];

    logic [5:0]   o_level_reg;
    logic [63:0]  o_cwlo_reg, o_cwhi_reg, o_vcw_reg, o_ocw_reg;
    logic [127:0] o_r0_reg, o_r1_reg;
    logic         o_last_reg;

    logic [127:0]   rnd_st, rnd_key, enc_key;
    dkg_round_ctl_t rctl;
    logic [6:0]     nb_in;
    logic           keep, ti0, ti1, tl, tr, tk, is_last;
    logic [127:0]   sx0, sx1, scw, c0k, c1k;
    logic [63:0]    c0v_n, c1v_n, c0v_k, c1v_k;
    logic [63:0]    p0m, p1m;

    assign rctl.rcon        = rcon(rnd_reg);
    assign rctl.final_round = (rnd_reg == LastRound);

    dkg_aes_round u_round (
        .state_in  (aes_st_reg),
        .key_in    (aes_key_reg),
        .ctl       (rctl),
        .state_out (rnd_st),
        .key_out   (rnd_key)
    );

    always_comb begin
        nb_in = (bin_bits_reg == 7'd0) ? 7'd1 :
                ((bin_bits_reg > MaxLevels) ? MaxLevels : bin_bits_reg);
        // AES key: running seed with its two low bits cleared
        enc_key = enc_reg[2] ? {p1_reg[127:2], 2'b00} : {p0_reg[127:2], 2'b00};
        keep    = alpha_reg[63];
        ti0     = p0_reg[0];
        ti1     = p1_reg[0];
        sx0     = ct_reg[0] ^ ct_reg[4];
        sx1     = ct_reg[1] ^ ct_reg[5];
        tl      = sx0[0] ^ keep ^ 1'b1;
        tr      = sx1[0] ^ keep;
        scw     = keep ? {sx0[127:2], 2'b00} : {sx1[127:2], 2'b00};
        tk      = keep ? tr : tl;
        c0k     = keep ? ct_reg[1] : ct_reg[0];
        c1k     = keep ? ct_reg[5] : ct_reg[4];
        c0v_n   = keep ? ct_reg[2][63:0] : ct_reg[3][63:0];
        c1v_n   = keep ? ct_reg[6][63:0] : ct_reg[7][63:0];
        c0v_k   = keep ? ct_reg[3][63:0] : ct_reg[2][63:0];
        c1v_k   = keep ? ct_reg[7][63:0] : ct_reg[6][63:0];
        is_last = ({1'b0, lvl_reg} == (nb_reg - 7'd1));
        p0m     = {p0_reg[63:2], 2'b00};
        p1m     = {p1_reg[63:2], 2'b00};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_INIT;
            S_INIT:  state_next = S_ROUND;
            S_ROUND: begin
                if (rnd_reg == LastRound) begin
                    state_next = (enc_reg == LastEnc) ? S_VAL : S_INIT;
                end
            end
            S_VAL:   state_next = S_V2;
            S_V2:    state_next = S_UPD;
            S_UPD:   state_next = is_last ? S_FIN : S_OUT;
            S_FIN:   state_next = S_OUT;
            S_OUT: begin
                if (m_tready) state_next = o_last_reg ? S_IDLE : S_INIT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            bin_bits_reg <= MaxLevels;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) bin_bits_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    // align the top used bit of alpha to bit 63
                    alpha_reg   <= s_tdata[63:0] << (7'd64 - nb_in);
                    payload_reg <= s_tdata[127:64];
                    nb_reg      <= nb_in;
                    p1_reg      <= s_tdata[383:256];
                    p0_reg      <= {s_tdata[255:129], ~s_tdata[256]};
                    root1_reg   <= s_tdata[383:256];
                    root0_reg   <= {s_tdata[255:129], ~s_tdata[256]};
                    acc_reg     <= 64'd0;
                    lvl_reg     <= 6'd0;
                    enc_reg     <= 3'd0;
                end
            end
            S_INIT: begin
                aes_key_reg <= enc_key;
                aes_st_reg  <= enc_key ^ {126'd0, enc_reg[1:0]};
                rnd_reg     <= 4'd1;
            end
            S_ROUND: begin
                aes_st_reg  <= rnd_st;
                aes_key_reg <= rnd_key;
                rnd_reg     <= rnd_reg + 4'd1;
                if (rnd_reg == LastRound) begin
                    ct_reg[enc_reg] <= rnd_st;
                    enc_reg         <= enc_reg + 3'd1;
                end
            end
            S_VAL: tmp_reg <= c1v_n - c0v_n - acc_reg;
            S_V2: begin
                v0_reg <= cond_neg(ti1, tmp_reg) +
                          (keep ? cond_neg(ti1, payload_reg) : 64'd0);
            end
            S_UPD: begin
                acc_reg     <= acc_reg - c1v_k + c0v_k + cond_neg(ti1, v0_reg);
                p0_reg      <= c0k ^ (ti0 ? {scw[127:1], tk} : 128'd0);
                p1_reg      <= c1k ^ (ti1 ? {scw[127:1], tk} : 128'd0);
                o_level_reg <= lvl_reg;
                o_cwlo_reg  <= {scw[63:2], tl, tr};
                o_cwhi_reg  <= scw[127:64];
                o_vcw_reg   <= v0_reg;
                o_r0_reg    <= 128'd0;
                o_r1_reg    <= 128'd0;
                o_ocw_reg   <= 64'd0;
                o_last_reg  <= is_last;
                alpha_reg   <= {alpha_reg[62:0], 1'b0};
            end
            S_FIN: begin
                o_r0_reg  <= root0_reg;
                o_r1_reg  <= root1_reg;
                o_ocw_reg <= p1_reg[0] ? (acc_reg + p0m - p1m) : (p1m - p0m - acc_reg);
            end
            S_OUT: begin
                if (m_tready) begin
                    lvl_reg <= lvl_reg + 6'd1;
                    enc_reg <= 3'd0;
                end
            end
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tlast   = o_last_reg;
    assign m_tdata   = {2'b00, o_ocw_reg, o_r1_reg, o_r0_reg, o_vcw_reg,
                        o_cwhi_reg, o_cwlo_reg, o_level_reg};

    // never take a request while a result is being offered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output both open");

    // the final transaction returns the block to idle
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not idle after last transaction");

    // roots and output correction only travel with the final transaction
    a_roots: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[517:198] == 320'd0)
        else $error("root fields set on non-final transaction");

endmodule

// ----- tb/sv/tb_dcf_key_generation.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dcf_key_generation: drives key-generation requests,
// predicts every level's correction words with an internal AES-128 model. Depends on dkg_pkg.
module tb_dcf_key_generation;
    import dkg_pkg::*;

    typedef struct packed {
        logic [63:0] seed1_hi;
        logic [63:0] seed1_lo;
        logic [63:0] seed0_hi;
        logic [63:0] seed0_lo;
        logic [63:0] payload;
        logic [63:0] alpha;
    } request_t;

    typedef struct packed {
        logic [1:0]  fill;
        logic [63:0] output_cw;
        logic [63:0] root1_hi;
        logic [63:0] root1_lo;
        logic [63:0] root0_hi;
        logic [63:0] root0_lo;
        logic [63:0] value_cw;
        logic [63:0] cw_hi;
        logic [63:0] cw_lo;
        logic [5:0]  level;
    } level_word_t;

    typedef struct {
        level_word_t w;
        logic        last;
    } level_exp_t;

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [6:0] cfg_data;
    logic s_tvalid, s_tready;
    logic [InWidth-1:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [OutWidth-1:0] m_tdata;
    logic m_tlast;

    dcf_key_generation DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Predictor's copy of the level-count register.
    logic [6:0] levels_reg;

    request_t   pending_reqs[$];
    level_exp_t expected_levels[$];
    int unsigned errors;
    longint unsigned cycle_count;
    bit quiet;          // no idling on either side while set
    bit sender_hold;    // sender pauses until all results have arrived

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 on a little-endian block: byte i sits at bits 8i+7:8i.
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] pt);
        logic [7:0] rk[176];
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] t[4];
        logic [7:0] f, a0, a1, a2, a3, all;
        logic [7:0] rc;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
            if ((i % 16) == 0) begin
                f = t[0];
                t[0] = SBOX[t[1]] ^ rc;
                t[1] = SBOX[t[2]];
                t[2] = SBOX[t[3]];
                t[3] = SBOX[f];
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
        end
        for (int i = 0; i < 16; i++) st[i] = pt[8*i +: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    tmp[c*4+j] = SBOX[st[((c+j) % 4)*4+j]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = tmp[c*4]; a1 = tmp[c*4+1]; a2 = tmp[c*4+2]; a3 = tmp[c*4+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    tmp[c*4]   = a0 ^ all ^ dbl(a0 ^ a1);
                    tmp[c*4+1] = a1 ^ all ^ dbl(a1 ^ a2);
                    tmp[c*4+2] = a2 ^ all ^ dbl(a2 ^ a3);
                    tmp[c*4+3] = a3 ^ all ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[r*16+i];
        end
        for (int i = 0; i < 16; i++) res[8*i +: 8] = st[i];
        return res;
    endfunction

    function automatic logic [63:0] neg_if(input logic n, input logic [63:0] x);
        return n ? 64'd0 - x : x;
    endfunction

    // Walk the tree for one request and queue one expectation per level.
    task automatic predict_key(input request_t rq);
        int nb;
        logic [127:0] p0, p1, r0, r1, k0, k1, scw, sx0, sx1, pick;
        logic [127:0] c0[4];
        logic [127:0] c1[4];
        logic [63:0] vacc, v0, g;
        logic keep, ti0, ti1, tl, tr, tk;
        level_exp_t e;
        nb = (levels_reg == 0) ? 1 : (levels_reg > 64 ? 64 : int'(levels_reg));
        p1 = {rq.seed1_hi, rq.seed1_lo};
        p0 = {rq.seed0_hi, rq.seed0_lo[63:1], ~rq.seed1_lo[0]};
        r0 = p0;
        r1 = p1;
        vacc = '0;
        for (int i = 0; i < nb; i++) begin
            keep = rq.alpha[nb-1-i];
            k0 = {p0[127:2], 2'b00};
            k1 = {p1[127:2], 2'b00};
            for (int n = 0; n < 4; n++) begin
                c0[n] = aes_encrypt(k0, 128'(n));
                c1[n] = aes_encrypt(k1, 128'(n));
            end
            ti0 = p0[0];
            ti1 = p1[0];
            v0 = neg_if(ti1, 64'd0 - vacc - c0[2 + (keep ^ 1)][63:0]
                              + c1[2 + (keep ^ 1)][63:0]);
            if (keep) v0 += neg_if(ti1, rq.payload);
            vacc = vacc - c1[2 + keep][63:0] + c0[2 + keep][63:0] + neg_if(ti1, v0);
            sx0 = c0[0] ^ c1[0];
            sx1 = c0[1] ^ c1[1];
            tl = sx0[0] ^ keep ^ 1'b1;
            tr = sx1[0] ^ keep;
            pick = keep ? sx0 : sx1;
            scw = {pick[127:2], 2'b00};
            tk = keep ? tr : tl;
            e.w = '0;
            e.w.level = 6'(i);
            e.w.cw_lo = scw[63:0] ^ {62'd0, tl, tr};
            e.w.cw_hi = scw[127:64];
            e.w.value_cw = v0;
            e.last = 1'b0;
            p0 = c0[keep] ^ (ti0 ? (scw ^ 128'(tk)) : 128'd0);
            p1 = c1[keep] ^ (ti1 ? (scw ^ 128'(tk)) : 128'd0);
            if (i == nb - 1) begin
                g = {p1[63:2], 2'b00} - {p0[63:2], 2'b00} - vacc;
                e.w.root0_lo = r0[63:0];
                e.w.root0_hi = r0[127:64];
                e.w.root1_lo = r1[63:0];
                e.w.root1_hi = r1[127:64];
                e.w.output_cw = neg_if(p1[0], g);
                e.last = 1'b1;
            end
            expected_levels.push_back(e);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic request_t random_request();
        request_t rq;
        rq.alpha = rand64();
        rq.payload = rand64();
        rq.seed0_lo = rand64();
        rq.seed0_hi = rand64();
        rq.seed1_lo = rand64();
        rq.seed1_hi = rand64();
        return rq;
    endfunction

    // Driver: hold s_tvalid until the transaction is taken, then advance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                // The request just accepted leaves the queue and is predicted.
                predict_key(pending_reqs.pop_front());
            end
            if (pending_reqs.size() != 0 && !sender_hold
                && (quiet || $urandom_range(99) >= 38)) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_reqs[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted level result against the oldest expectation.
    always @(posedge aclk) begin
        level_exp_t e;
        level_word_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = level_word_t'(m_tdata);
                if (expected_levels.size() == 0) begin
                    $display("%0t: unexpected result level %0d", $time, got.level);
                    errors++;
                end else begin
                    e = expected_levels.pop_front();
                    if (got.level !== e.w.level) begin
                        $display("%0t: level exp %0d got %0d", $time, e.w.level, got.level);
                        errors++;
                    end
                    if (got.cw_lo !== e.w.cw_lo) begin
                        $display("%0t: cw_lo exp %h got %h", $time, e.w.cw_lo, got.cw_lo);
                        errors++;
                    end
                    if (got.cw_hi !== e.w.cw_hi) begin
                        $display("%0t: cw_hi exp %h got %h", $time, e.w.cw_hi, got.cw_hi);
                        errors++;
                    end
                    if (got.value_cw !== e.w.value_cw) begin
                        $display("%0t: value_cw exp %h got %h", $time, e.w.value_cw,
                                 got.value_cw);
                        errors++;
                    end
                    if (got.root0_lo !== e.w.root0_lo) begin
                        $display("%0t: root0_lo exp %h got %h", $time, e.w.root0_lo,
                                 got.root0_lo);
                        errors++;
                    end
                    if (got.root0_hi !== e.w.root0_hi) begin
                        $display("%0t: root0_hi exp %h got %h", $time, e.w.root0_hi,
                                 got.root0_hi);
                        errors++;
                    end
                    if (got.root1_lo !== e.w.root1_lo) begin
                        $display("%0t: root1_lo exp %h got %h", $time, e.w.root1_lo,
                                 got.root1_lo);
                        errors++;
                    end
                    if (got.root1_hi !== e.w.root1_hi) begin
                        $display("%0t: root1_hi exp %h got %h", $time, e.w.root1_hi,
                                 got.root1_hi);
                        errors++;
                    end
                    if (got.output_cw !== e.w.output_cw) begin
                        $display("%0t: output_cw exp %h got %h", $time, e.w.output_cw,
                                 got.output_cw);
                        errors++;
                    end
                    if (got.fill !== 2'b00) begin
                        $display("%0t: fill exp 0 got %b", $time, got.fill);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $display("%0t: tlast exp %b got %b", $time, e.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= quiet || ($urandom_range(99) >= 38);
        end
    end

    // Cycle limit: worst case is a request of 64 levels, stretched by stalls.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd6_000_000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Wait until every queued request is taken and every result is back.
    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_levels(input logic [6:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        levels_reg = v;
    endtask

    initial begin
        request_t rq;
        logic [6:0] lv;
        int n;
        errors = 0;
        cycle_count = 0;
        quiet = 1'b0;
        sender_hold = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        levels_reg = MaxLevels;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset depth of 64 levels, all-zero and all-one fields.
        pending_reqs.push_back('0);
        pending_reqs.push_back('1);
        drain();

        // Extremes of the level register, including the out-of-range codes.
        write_levels(7'd1);
        pending_reqs.push_back('0);
        rq = random_request(); rq.alpha = 64'd1; pending_reqs.push_back(rq);
        rq = random_request(); rq.alpha = '1; rq.payload = '1; pending_reqs.push_back(rq);
        drain();
        write_levels(7'd0);
        pending_reqs.push_back(random_request());
        drain();
        write_levels(7'd127);
        pending_reqs.push_back(random_request());
        drain();
        write_levels(7'd65);
        rq = random_request(); rq.alpha = 64'h8000_0000_0000_0000; pending_reqs.push_back(rq);
        drain();
        write_levels(7'd3);
        for (int i = 0; i < 8; i++) begin
            // Walk alpha over every path at depth 3; junk bits above must be ignored.
            rq = random_request();
            rq.alpha = {rq.alpha[63:3], 3'(i)};
            rq.seed1_lo[0] = i[0];
            pending_reqs.push_back(rq);
        end
        drain();

        // Random phases; mostly shallow trees, a few deep ones.
        n = 0;
        while (n < 100) begin
            case ($urandom_range(9))
                0: lv = 7'd64;
                1: lv = 7'(32 + $urandom_range(31));
                2: lv = $urandom_range(1) ? 7'd0 : 7'(65 + $urandom_range(62));
                default: lv = 7'(1 + $urandom_range(7));
            endcase
            write_levels(lv);
            quiet = ($urandom_range(5) == 0);
            for (int i = 0; i < 10; i++) pending_reqs.push_back(random_request());
            n += 10;
            if (n == 50) begin
                // Hold the sender off until every outstanding result is back.
                while (pending_reqs.size() > 5 || s_tvalid) @(posedge aclk);
                sender_hold = 1'b1;
                @(posedge aclk);
                while (expected_levels.size() != 0 || s_tvalid) @(posedge aclk);
                sender_hold = 1'b0;
            end
            drain();
            quiet = 1'b0;
        end

        if (errors == 0 && expected_levels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dkg_pkg.sv
rtl/dkg_aes_round.sv
rtl/dcf_key_generation.sv
tb/sv/tb_dcf_key_generation.sv
